// File: hdl/bufp_pkg.sv
package bufp_pkg;

  localparam int unsigned OpW   = 3;
  localparam int unsigned ByteW = 8;
  localparam int unsigned ErrW  = 2;

  // Bit positions in the sticky error flags
  localparam int unsigned ErrFrameBit    = 0;
  localparam int unsigned ErrOverflowBit = 1;

  typedef enum logic [OpW-1:0] {
    OP_RX_READ    = 3'd0,
    OP_TX_WRITE   = 3'd1,
    OP_LINE_BYTE  = 3'd2,
    OP_LINE_READY = 3'd3,
    OP_READ_ERR   = 3'd4,
    OP_FLUSH_RX   = 3'd5,
    OP_FLUSH_TX   = 3'd6
  } op_e;

  // Everything about one result except the bytes read from the rings
  typedef struct packed {
    logic            rx_hit;
    logic            tx_hit;
    logic [ErrW-1:0] err_val;
    logic            push_ok;
    logic            rx_ready;
    logic            tx_space;
    logic            rx_en;
    logic            tx_en;
  } res_t;

endpackage

// File: hdl/bufp_if.sv
interface bufp_in_if
  import bufp_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [OpW-1:0]   operation;
  logic [ByteW-1:0] data_in;
  logic             line_frame_error;
  logic             line_overrun;

  modport source (
    output valid, operation, data_in, line_frame_error, line_overrun,
    input  ready
  );
  modport sink (
    input  valid, operation, data_in, line_frame_error, line_overrun,
    output ready
  );
endinterface

interface bufp_out_if
  import bufp_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_data;
  logic             rx_data_valid;
  logic [ByteW-1:0] tx_line_data;
  logic             tx_line_valid;
  logic [ErrW-1:0]  error_value;
  logic             push_accepted;
  logic             rx_ready;
  logic             tx_space;
  logic             rx_enabled_out;
  logic             tx_enabled_out;

  modport source (
    output valid, rx_data, rx_data_valid, tx_line_data, tx_line_valid, error_value,
           push_accepted, rx_ready, tx_space, rx_enabled_out, tx_enabled_out,
    input  ready
  );
  modport sink (
    input  valid, rx_data, rx_data_valid, tx_line_data, tx_line_valid, error_value,
           push_accepted, rx_ready, tx_space, rx_enabled_out, tx_enabled_out,
    output ready
  );
endinterface

// File: hdl/bufp_ram.sv
module bufp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/buffered_uart_fifo_pair.sv
// Receive and transmit byte rings between a host and a UART line.
// in_i carries one operation per transfer: host read of the receive ring,
// host write to the transmit ring, a byte arriving from the line, a ready
// event from the line transmitter, a read-and-clear of the sticky error
// flags, or a flush of either ring. out_o carries exactly one result per
// operation, in order, with the byte popped (if any) and the ring status.
// Each ring holds RX_DEPTH-1 or TX_DEPTH-1 bytes, one slot being kept empty.
// A result passes through the pending stage, which takes the synchronous
// ring read, and then through the output register to out_o.
// Throughput: one operation per cycle while out_o does not stall; pointers
// and flags update in the accept cycle, so back-to-back operations see each
// other's effects. When out_o stalls, the output register and one pending
// stage fill and in_i.ready drops until out_o takes a transfer.
// Reset empties both rings, clears the error flags, enables reception and
// disables transmit service. Ring contents are not cleared and need no
// clearing pass.
module buffered_uart_fifo_pair
  import bufp_pkg::*;
#(
  parameter int unsigned RX_DEPTH = 16,
  parameter int unsigned TX_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bufp_in_if.sink    in_i,
  bufp_out_if.source out_o
);

  localparam int unsigned RxAw = $clog2(RX_DEPTH);
  localparam int unsigned TxAw = $clog2(TX_DEPTH);
  localparam logic [RxAw-1:0] RxLast = RxAw'(RX_DEPTH - 1);
  localparam logic [TxAw-1:0] TxLast = TxAw'(TX_DEPTH - 1);

  logic [RxAw-1:0] rx_wr_q, rx_wr_d, rx_rd_q, rx_rd_d, rx_wr_nx, rx_rd_nx;
  logic [TxAw-1:0] tx_wr_q, tx_wr_d, tx_rd_q, tx_rd_d, tx_wr_nx, tx_rd_nx, tx_wr_nx_d;
  logic [ErrW-1:0] err_q, err_d;
  logic            rx_en_q, rx_en_d, tx_en_q, tx_en_d;

  logic             accept;
  logic             rx_we, rx_re, tx_we, tx_re;
  logic [ByteW-1:0] rx_rdata, tx_rdata;
  res_t             res;

  logic             pend_valid_q, pend_valid_d, pend_adv;
  res_t             pend_q;
  logic             out_valid_q, out_valid_d;
  res_t             out_res_q;
  logic [ByteW-1:0] out_rx_data_q, out_tx_data_q;

  assign rx_wr_nx   = (rx_wr_q == RxLast) ? '0 : rx_wr_q + 1'b1;
  assign rx_rd_nx   = (rx_rd_q == RxLast) ? '0 : rx_rd_q + 1'b1;
  assign tx_wr_nx   = (tx_wr_q == TxLast) ? '0 : tx_wr_q + 1'b1;
  assign tx_rd_nx   = (tx_rd_q == TxLast) ? '0 : tx_rd_q + 1'b1;
  assign tx_wr_nx_d = (tx_wr_d == TxLast) ? '0 : tx_wr_d + 1'b1;

  // Hold the input while the pending stage cannot move on
  assign pend_adv   = pend_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !pend_valid_q || pend_adv;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    rx_wr_d = rx_wr_q;
    rx_rd_d = rx_rd_q;
    tx_wr_d = tx_wr_q;
    tx_rd_d = tx_rd_q;
    err_d   = err_q;
    rx_en_d = rx_en_q;
    tx_en_d = tx_en_q;
    rx_we   = 1'b0;
    rx_re   = 1'b0;
    tx_we   = 1'b0;
    tx_re   = 1'b0;
    res     = '0;
    if (accept) begin
      case (op_e'(in_i.operation))
        OP_RX_READ: begin
          if (rx_rd_q != rx_wr_q) begin
            rx_re      = 1'b1;
            res.rx_hit = 1'b1;
            rx_rd_d    = rx_rd_nx;
          end
          rx_en_d = 1'b1;
        end
        OP_TX_WRITE: begin
          if (tx_wr_nx != tx_rd_q) begin
            tx_we       = 1'b1;
            tx_wr_d     = tx_wr_nx;
            tx_en_d     = 1'b1;
            res.push_ok = 1'b1;
          end
        end
        OP_LINE_BYTE: begin
          if (!rx_en_q) begin
            err_d[ErrOverflowBit] = 1'b1;
          end else begin
            if (in_i.line_frame_error) begin
              err_d[ErrFrameBit] = 1'b1;
            end
            if (in_i.line_overrun) begin
              err_d[ErrOverflowBit] = 1'b1;
            end
            if (rx_wr_nx == rx_rd_q) begin
              // Drop the byte and hold off reception until the next host read
              rx_en_d               = 1'b0;
              err_d[ErrOverflowBit] = 1'b1;
            end else begin
              rx_we   = 1'b1;
              rx_wr_d = rx_wr_nx;
            end
          end
        end
        OP_LINE_READY: begin
          if (tx_en_q) begin
            if (tx_wr_q == tx_rd_q) begin
              tx_en_d = 1'b0;
            end else begin
              tx_re      = 1'b1;
              res.tx_hit = 1'b1;
              tx_rd_d    = tx_rd_nx;
            end
          end
        end
        OP_READ_ERR: begin
          res.err_val = err_q;
          err_d       = '0;
        end
        OP_FLUSH_RX: rx_rd_d = rx_wr_q;
        OP_FLUSH_TX: tx_wr_d = tx_rd_q;
        default: ;
      endcase
    end
    res.rx_ready = (rx_rd_d != rx_wr_d);
    res.tx_space = (tx_wr_nx_d != tx_rd_d);
    res.rx_en    = rx_en_d;
    res.tx_en    = tx_en_d;
  end

  bufp_ram #(.Width(ByteW), .Depth(RX_DEPTH)) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_wr_q),
    .wdata_i (in_i.data_in),
    .re_i    (rx_re),
    .raddr_i (rx_rd_q),
    .rdata_o (rx_rdata)
  );

  bufp_ram #(.Width(ByteW), .Depth(TX_DEPTH)) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (tx_we),
    .waddr_i (tx_wr_q),
    .wdata_i (in_i.data_in),
    .re_i    (tx_re),
    .raddr_i (tx_rd_q),
    .rdata_o (tx_rdata)
  );

  always_comb begin
    pend_valid_d = pend_valid_q;
    if (accept) begin
      pend_valid_d = 1'b1;
    end else if (pend_adv) begin
      pend_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (pend_adv) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_wr_q      <= '0;
      rx_rd_q      <= '0;
      tx_wr_q      <= '0;
      tx_rd_q      <= '0;
      err_q        <= '0;
      rx_en_q      <= 1'b1;
      tx_en_q      <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      rx_wr_q      <= rx_wr_d;
      rx_rd_q      <= rx_rd_d;
      tx_wr_q      <= tx_wr_d;
      tx_rd_q      <= tx_rd_d;
      err_q        <= err_d;
      rx_en_q      <= rx_en_d;
      tx_en_q      <= tx_en_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // The ring read data stays put until the next accepted read, so the
  // pending stage may wait on the output without losing it
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_q <= res;
    end
    if (pend_adv) begin
      out_res_q     <= pend_q;
      out_rx_data_q <= pend_q.rx_hit ? rx_rdata : '0;
      out_tx_data_q <= pend_q.tx_hit ? tx_rdata : '0;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.rx_data        = out_rx_data_q;
  assign out_o.rx_data_valid  = out_res_q.rx_hit;
  assign out_o.tx_line_data   = out_tx_data_q;
  assign out_o.tx_line_valid  = out_res_q.tx_hit;
  assign out_o.error_value    = out_res_q.err_val;
  assign out_o.push_accepted  = out_res_q.push_ok;
  assign out_o.rx_ready       = out_res_q.rx_ready;
  assign out_o.tx_space       = out_res_q.tx_space;
  assign out_o.rx_enabled_out = out_res_q.rx_en;
  assign out_o.tx_enabled_out = out_res_q.tx_en;

endmodule

// File: hdl/bufp_checker.sv
module bufp_checker
  import bufp_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [ByteW-1:0] rx_data_i,
  input logic             rx_data_valid_i,
  input logic             tx_line_valid_i,
  input logic [ErrW-1:0]  error_value_i,
  input logic             push_accepted_i,
  input logic             rx_enabled_i,
  input logic             tx_enabled_i
);

  // A stalled result stays valid with its receive byte held until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(rx_data_i))
    else $error("result changed while stalled");

  // One operation reports at most one kind of transfer
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> $onehot0({rx_data_valid_i, tx_line_valid_i, push_accepted_i,
                              error_value_i != '0}))
    else $error("result reports more than one kind of transfer");

  // A host read that returns a byte reenables reception
  a_read_enables: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && rx_data_valid_i |-> rx_enabled_i)
    else $error("reception held off after host read");

  // An accepted host write turns on transmit service
  a_push_enables: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && push_accepted_i |-> tx_enabled_i)
    else $error("transmit service off after accepted write");

  // A byte handed to the line leaves transmit service on
  a_line_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && tx_line_valid_i |-> tx_enabled_i)
    else $error("byte sent while transmit service off");

endmodule

bind buffered_uart_fifo_pair bufp_checker u_bufp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .rx_data_i       (out_o.rx_data),
  .rx_data_valid_i (out_o.rx_data_valid),
  .tx_line_valid_i (out_o.tx_line_valid),
  .error_value_i   (out_o.error_value),
  .push_accepted_i (out_o.push_accepted),
  .rx_enabled_i    (out_o.rx_enabled_out),
  .tx_enabled_i    (out_o.tx_enabled_out)
);

// File: test/tb_buffered_uart_fifo_pair.sv
`timescale 1ns / 100ps

module tb_buffered_uart_fifo_pair;
  import bufp_pkg::*;

  localparam int unsigned RxDepth     = 16;
  localparam int unsigned TxDepth     = 16;
  localparam int unsigned NumRandom   = 800;
  localparam int unsigned DrainEvery  = 200;
  localparam int unsigned LongHoldAt  = 300;
  localparam int unsigned LongHoldLen = 80;
  localparam int unsigned TailCycles  = 10;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned MaxReports  = 10;

  typedef struct {
    op_e              op;
    logic [ByteW-1:0] data;
    logic             fe;
    logic             dor;
    bit               drain;  // wait for every outstanding result first
  } uart_op_t;

  typedef struct packed {
    logic [ByteW-1:0] rx_data;
    logic             rx_data_valid;
    logic [ByteW-1:0] tx_line_data;
    logic             tx_line_valid;
    logic [ErrW-1:0]  error_value;
    logic             push_accepted;
    logic             rx_ready;
    logic             tx_space;
    logic             rx_en;
    logic             tx_en;
  } uart_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  bufp_in_if  op_if ();
  bufp_out_if res_if ();

  buffered_uart_fifo_pair #(
    .RX_DEPTH(RxDepth),
    .TX_DEPTH(TxDepth)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (op_if),
    .out_o (res_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of both rings and the flags
  logic [ByteW-1:0] rx_ring [RxDepth];
  logic [ByteW-1:0] tx_ring [TxDepth];
  int unsigned      rx_wr, rx_rd, tx_wr, tx_rd;
  logic [ErrW-1:0]  err_flags;
  logic             rx_on, tx_on;

  int unsigned op_counts [7];
  int unsigned rx_drops, tx_rejects;
  int unsigned err_cnt;

  uart_op_t     uart_ops [$];
  uart_result_t ring_results_q [$];

  function automatic int unsigned ring_next(int unsigned p, int unsigned depth);
    return (p + 1 >= depth) ? 0 : p + 1;
  endfunction

  function automatic uart_result_t apply_uart_op(uart_op_t it);
    uart_result_t r;
    int unsigned  nx;
    r = '0;
    op_counts[it.op]++;
    case (it.op)
      OP_RX_READ: begin
        if (rx_rd != rx_wr) begin
          r.rx_data       = rx_ring[rx_rd];
          r.rx_data_valid = 1'b1;
          rx_rd           = ring_next(rx_rd, RxDepth);
        end
        rx_on = 1'b1;
      end
      OP_TX_WRITE: begin
        nx = ring_next(tx_wr, TxDepth);
        if (nx != tx_rd) begin
          tx_ring[tx_wr]  = it.data;
          tx_wr           = nx;
          tx_on           = 1'b1;
          r.push_accepted = 1'b1;
        end else begin
          tx_rejects++;
        end
      end
      OP_LINE_BYTE: begin
        if (!rx_on) begin
          // held off: drop and flag, line status is ignored
          err_flags[ErrOverflowBit] = 1'b1;
          rx_drops++;
        end else begin
          if (it.fe) err_flags[ErrFrameBit] = 1'b1;
          if (it.dor) err_flags[ErrOverflowBit] = 1'b1;
          nx = ring_next(rx_wr, RxDepth);
          if (nx == rx_rd) begin
            rx_on                     = 1'b0;
            err_flags[ErrOverflowBit] = 1'b1;
            rx_drops++;
          end else begin
            rx_ring[rx_wr] = it.data;
            rx_wr          = nx;
          end
        end
      end
      OP_LINE_READY: begin
        if (tx_on) begin
          if (tx_wr == tx_rd) begin
            tx_on = 1'b0;
          end else begin
            r.tx_line_data  = tx_ring[tx_rd];
            r.tx_line_valid = 1'b1;
            tx_rd           = ring_next(tx_rd, TxDepth);
          end
        end
      end
      OP_READ_ERR: begin
        r.error_value = err_flags;
        err_flags     = '0;
      end
      OP_FLUSH_RX: rx_rd = rx_wr;
      OP_FLUSH_TX: tx_wr = tx_rd;
      default: ;
    endcase
    r.rx_ready = (rx_rd != rx_wr);
    r.tx_space = (ring_next(tx_wr, TxDepth) != tx_rd);
    r.rx_en    = rx_on;
    r.tx_en    = tx_on;
    return r;
  endfunction

  function automatic int unsigned pick_idle(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic string fmt_result(uart_result_t r);
    return $sformatf("rx %h/%b tx %h/%b err %b push %b rdy %b space %b rx_en %b tx_en %b",
                     r.rx_data, r.rx_data_valid, r.tx_line_data, r.tx_line_valid,
                     r.error_value, r.push_accepted, r.rx_ready, r.tx_space,
                     r.rx_en, r.tx_en);
  endfunction

  task automatic queue_op(op_e op, logic [ByteW-1:0] data, logic fe, logic dor);
    uart_op_t it;
    it.op    = op;
    it.data  = data;
    it.fe    = fe;
    it.dor   = dor;
    it.drain = (uart_ops.size() % DrainEvery == DrainEvery - 1);
    uart_ops.push_back(it);
  endtask

  // Driver
  uart_op_t    cur_op;
  bit          op_busy, op_calm, op_took;
  int unsigned op_idle, sent_now;
  int unsigned sent_cnt, got_cnt;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_if.valid            <= 1'b0;
      op_if.operation        <= '0;
      op_if.data_in          <= '0;
      op_if.line_frame_error <= 1'b0;
      op_if.line_overrun     <= 1'b0;
      sent_cnt               <= 0;
      cur_op    = '{OP_RX_READ, '0, 1'b0, 1'b0, 1'b0};
      op_busy   = 1'b0;
      op_calm   = 1'b0;
      op_idle   = 0;
      rx_wr     = 0;
      rx_rd     = 0;
      tx_wr     = 0;
      tx_rd     = 0;
      err_flags = '0;
      rx_on     = 1'b1;
      tx_on     = 1'b0;
    end else begin
      op_took = op_if.valid && op_if.ready;
      if (op_took) begin
        ring_results_q.push_back(apply_uart_op(cur_op));
        op_busy = 1'b0;
      end
      sent_now = sent_cnt + op_took;
      if (!op_busy) begin
        if (op_idle > 0) begin
          op_idle--;
        end else if (uart_ops.size() > 0 &&
                     (!uart_ops[0].drain || sent_now == got_cnt)) begin
          cur_op  = uart_ops.pop_front();
          op_busy = 1'b1;
          if ($urandom_range(0, 49) == 0) op_calm = !op_calm;
          op_idle = pick_idle(op_calm);
        end
      end
      sent_cnt               <= sent_now;
      op_if.valid            <= op_busy;
      op_if.operation        <= cur_op.op;
      op_if.data_in          <= cur_op.data;
      op_if.line_frame_error <= cur_op.fe;
      op_if.line_overrun     <= cur_op.dor;
    end
  end

  // Monitor and checker
  uart_result_t seen, want;
  bit           res_calm, res_rdy, long_hold_done;
  int unsigned  res_hold;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready   <= 1'b0;
      got_cnt        <= 0;
      res_hold       = 0;
      res_calm       = 1'b0;
      long_hold_done = 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        seen.rx_data       = res_if.rx_data;
        seen.rx_data_valid = res_if.rx_data_valid;
        seen.tx_line_data  = res_if.tx_line_data;
        seen.tx_line_valid = res_if.tx_line_valid;
        seen.error_value   = res_if.error_value;
        seen.push_accepted = res_if.push_accepted;
        seen.rx_ready      = res_if.rx_ready;
        seen.tx_space      = res_if.tx_space;
        seen.rx_en         = res_if.rx_enabled_out;
        seen.tx_en         = res_if.tx_enabled_out;
        if (ring_results_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MaxReports)
            $display("result %0d arrived with nothing outstanding: %s",
                     got_cnt, fmt_result(seen));
        end else begin
          want = ring_results_q.pop_front();
          if (seen !== want) begin
            err_cnt++;
            if (err_cnt <= MaxReports) begin
              $display("result %0d mismatch", got_cnt);
              $display("  want %s", fmt_result(want));
              $display("  got  %s", fmt_result(seen));
            end
          end
        end
        got_cnt <= got_cnt + 1;
      end

      if ($urandom_range(0, 99) == 0) res_calm = !res_calm;
      res_rdy = 1'b1;
      if (res_hold > 0) begin
        res_hold--;
        res_rdy = 1'b0;
      end else if (!long_hold_done && got_cnt >= LongHoldAt) begin
        // hold off long enough for the input side to back up
        long_hold_done = 1'b1;
        res_hold       = LongHoldLen - 1;
        res_rdy        = 1'b0;
      end else if (!res_calm && $urandom_range(0, 99) < 25) begin
        res_hold = pick_idle(1'b0);
        if (res_hold > 0) begin
          res_hold--;
          res_rdy = 1'b0;
        end
      end
      res_if.ready <= res_rdy;
    end
  end

  int unsigned cycle_cnt;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout: %0d of %0d results after %0d cycles",
               got_cnt, sent_cnt, cycle_cnt);
      $display("TEST FAILED");
      $finish;
    end
  end

  int unsigned total_items, burst_len, pick, k;
  op_e         burst_op, this_op;

  initial begin
    op_if.valid            = 1'b0;
    op_if.operation        = '0;
    op_if.data_in          = '0;
    op_if.line_frame_error = 1'b0;
    op_if.line_overrun     = 1'b0;
    res_if.ready           = 1'b0;

    // empty-ring read, line ready with service off, clean error read
    queue_op(OP_RX_READ, 8'h00, 1'b0, 1'b0);
    queue_op(OP_LINE_READY, 8'h00, 1'b0, 1'b0);
    queue_op(OP_READ_ERR, 8'h00, 1'b0, 1'b0);
    // two bytes out, then a ready event on an empty ring drops service
    queue_op(OP_TX_WRITE, 8'h00, 1'b0, 1'b0);
    queue_op(OP_TX_WRITE, 8'hFF, 1'b0, 1'b0);
    queue_op(OP_LINE_READY, 8'h00, 1'b0, 1'b0);
    queue_op(OP_LINE_READY, 8'h00, 1'b0, 1'b0);
    queue_op(OP_LINE_READY, 8'h00, 1'b0, 1'b0);
    // framing error and line overrun on received bytes
    queue_op(OP_LINE_BYTE, 8'hFF, 1'b1, 1'b0);
    queue_op(OP_LINE_BYTE, 8'h00, 1'b0, 1'b1);
    queue_op(OP_READ_ERR, 8'h00, 1'b0, 1'b0);
    queue_op(OP_RX_READ, 8'h00, 1'b0, 1'b0);
    queue_op(OP_RX_READ, 8'h00, 1'b0, 1'b0);
    queue_op(OP_LINE_BYTE, 8'h00, 1'b1, 1'b1);
    queue_op(OP_READ_ERR, 8'h00, 1'b0, 1'b0);
    // flushes leave the enable flags alone
    queue_op(OP_LINE_BYTE, 8'hA5, 1'b0, 1'b0);
    queue_op(OP_FLUSH_RX, 8'h00, 1'b0, 1'b0);
    queue_op(OP_RX_READ, 8'h00, 1'b0, 1'b0);
    queue_op(OP_TX_WRITE, 8'h5A, 1'b0, 1'b0);
    queue_op(OP_FLUSH_TX, 8'h00, 1'b0, 1'b0);
    queue_op(OP_LINE_READY, 8'h00, 1'b0, 1'b0);
    queue_op(OP_LINE_READY, 8'h00, 1'b0, 1'b0);

    // Bursts of one kind fill and drain the rings; a few stray ops mixed in
    total_items = uart_ops.size() + NumRandom;
    while (uart_ops.size() < total_items) begin
      pick      = $urandom_range(0, 99);
      burst_len = $urandom_range(1, 20);
      if (pick < 30) begin
        burst_op = OP_LINE_BYTE;
      end else if (pick < 55) begin
        burst_op = OP_TX_WRITE;
      end else if (pick < 75) begin
        burst_op = OP_RX_READ;
      end else if (pick < 92) begin
        burst_op = OP_LINE_READY;
      end else begin
        burst_len = 1;
        if (pick < 96) burst_op = OP_READ_ERR;
        else if (pick < 98) burst_op = OP_FLUSH_RX;
        else burst_op = OP_FLUSH_TX;
      end
      for (k = 0; k < burst_len; k++) begin
        this_op = burst_op;
        if ($urandom_range(0, 99) < 12) this_op = op_e'($urandom_range(0, 6));
        queue_op(this_op, ByteW'($urandom_range(0, 255)),
                 $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
      end
    end
    total_items = uart_ops.size();

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (sent_cnt != total_items || got_cnt < sent_cnt) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (ring_results_q.size() != 0) begin
      err_cnt += ring_results_q.size();
      $display("%0d results never arrived", ring_results_q.size());
    end

    $display("%0d ops: %0d rx reads, %0d tx writes, %0d line bytes, %0d line ready, %0d %s",
             total_items, op_counts[OP_RX_READ], op_counts[OP_TX_WRITE],
             op_counts[OP_LINE_BYTE], op_counts[OP_LINE_READY],
             op_counts[OP_READ_ERR], "error reads");
    $display("%0d rx flushes, %0d tx flushes, %0d bytes dropped, %0d writes refused, %0d bad",
             op_counts[OP_FLUSH_RX], op_counts[OP_FLUSH_TX], rx_drops, tx_rejects,
             err_cnt);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: buffered_uart_fifo_pair.f
hdl/bufp_pkg.sv
hdl/bufp_if.sv
hdl/bufp_ram.sv
hdl/buffered_uart_fifo_pair.sv
hdl/bufp_checker.sv
test/tb_buffered_uart_fifo_pair.sv
